/* src/modular_arithmetic_unit_defines.svh */
// Assertion macros for the modular arithmetic unit.
// Included by the top level; needs nothing else.
`ifndef MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MAU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mau: property failed");
`define MAU_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("mau: forbidden condition seen");
`else
`define MAU_ASSERT(label, clk, rst_n, prop)
`define MAU_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

/* src/mau_pkg.sv */
// Shared types and constants of the modular arithmetic unit.
// No dependencies.
package mau_pkg;

  localparam int ResBits = 31;
  localparam int ExpBits = 63;
  localparam int RawBits = 64;
  localparam int CntBits = 6;
  localparam int AddrBits = 3;
  localparam int DataBits = 32;
  localparam logic [ResBits-1:0] ModReset = ResBits'(998244353);

  typedef enum logic [2:0] {
    OpAdd = 3'd0,
    OpSub = 3'd1,
    OpNeg = 3'd2,
    OpMul = 3'd3,
    OpDiv = 3'd4,
    OpPow = 3'd5,
    OpInv = 3'd6,
    OpRed = 3'd7
  } mau_op_e;

  typedef enum logic [11:0] {
    SIdle   = 12'b0000_0000_0001,
    SRedA   = 12'b0000_0000_0010,
    SRedB   = 12'b0000_0000_0100,
    SMul    = 12'b0000_0000_1000,
    SPow    = 12'b0000_0001_0000,
    SPowMul = 12'b0000_0010_0000,
    SEuInit = 12'b0000_0100_0000,
    SEuTest = 12'b0000_1000_0000,
    SEuDiv  = 12'b0001_0000_0000,
    SEuUpd  = 12'b0010_0000_0000,
    SRed64  = 12'b0100_0000_0000,
    SOut    = 12'b1000_0000_0000
  } mau_state_e;

  typedef struct packed {
    logic [2:0]             operation;
    logic [ResBits-1:0]     operand_a;
    logic [ResBits-1:0]     operand_b;
    logic [ExpBits-1:0]     exponent;
    logic signed [RawBits-1:0] raw_value;
  } mau_in_t;

  typedef struct packed {
    logic [ResBits-1:0] result;
    logic               no_inverse;
  } mau_out_t;

  // one shift-and-reduce step: r' = ((2r + bit) mod d + addend) mod d
  typedef struct packed {
    logic [ResBits-1:0] rem;
    logic               bit_in;
    logic [ResBits-1:0] addend;
    logic [ResBits-1:0] divisor;
  } mau_step_in_t;

  typedef struct packed {
    logic [ResBits-1:0] nxt;
    logic               took;
  } mau_step_out_t;

endpackage

/* src/mau_step.sv */
// Shift, conditional subtract, add, conditional subtract step.
// Depends on mau_pkg.
module mau_step (
  input  mau_pkg::mau_step_in_t  step_i,
  output mau_pkg::mau_step_out_t step_o
);

  logic [mau_pkg::ResBits:0] div_w;
  logic [mau_pkg::ResBits:0] dbl;
  logic [mau_pkg::ResBits:0] red1;
  logic [mau_pkg::ResBits:0] sum;
  logic                      ge1;
  logic                      ge2;

  always_comb begin
    div_w = {1'b0, step_i.divisor};
    dbl   = {step_i.rem, step_i.bit_in};
    ge1   = dbl >= div_w;
    red1  = ge1 ? dbl - div_w : dbl;
    sum   = red1 + {1'b0, step_i.addend};
    ge2   = sum >= div_w;
    step_o.took = ge1;
    step_o.nxt  = ge2 ? mau_pkg::ResBits'(sum - div_w) : mau_pkg::ResBits'(sum);
  end

endmodule

/* src/mau_regs.sv */
// Configuration register file (modulus) behind an APB-style port.
// Depends on mau_pkg.
module mau_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mau_pkg::AddrBits-1:0] paddr,
  input  logic [mau_pkg::DataBits-1:0] pwdata,
  output logic [mau_pkg::DataBits-1:0] prdata,
  output logic                         pready,
  output logic [mau_pkg::ResBits-1:0]  modulus_o
);

  logic [mau_pkg::ResBits-1:0] mod_q, mod_d;
  logic                        sel_mod;
  logic                        wr;

  assign pready  = 1'b1;
  assign sel_mod = (paddr[2] == 1'b0);
  assign wr      = psel & penable & pwrite & sel_mod;

  always_comb begin
    mod_d = mod_q;
    if (wr) begin
      // zero modulus behaves as one
      mod_d = (pwdata[mau_pkg::ResBits-1:0] == '0) ? mau_pkg::ResBits'(1)
                                                   : pwdata[mau_pkg::ResBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= mau_pkg::ModReset;
    end else begin
      mod_q <= mod_d;
    end
  end

  assign prdata    = sel_mod ? {1'b0, mod_q} : '0;
  assign modulus_o = mod_q;

endmodule

/* src/mau_seq.sv */
// Sequencer and datapath registers; drives two shared step units.
// Depends on mau_pkg and mau_step.
module mau_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [mau_pkg::ResBits-1:0] modulus_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  mau_pkg::mau_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output mau_pkg::mau_out_t           out_data_o
);

  localparam int ResBits = mau_pkg::ResBits;
  localparam int RawBits = mau_pkg::RawBits;
  localparam int CntBits = mau_pkg::CntBits;
  localparam int PadBits = RawBits - ResBits;

  mau_pkg::mau_state_e state_q, state_d;
  mau_pkg::mau_op_e    op_q, op_d;

  logic [CntBits-1:0]          cnt_q, cnt_d;
  logic [ResBits-1:0]          m_q, m_d;
  logic [ResBits-1:0]          a_q, a_d, b_q, b_d;
  logic [mau_pkg::ExpBits-1:0] e_q, e_d;
  logic [RawBits-1:0]          sh_q, sh_d;
  logic [ResBits-1:0]          acc_q, acc_d, acc2_q, acc2_d;
  logic                        qbit_q, qbit_d;
  logic [ResBits-1:0]          r_q, r_d, x_q, x_d;
  logic [ResBits-1:0]          s_q, s_d, t_q, t_d, m0_q, m0_d, m1_q, m1_d;
  logic                        neg_q, neg_d;
  logic [ResBits-1:0]          res_q, res_d;
  logic                        flag_q, flag_d;

  mau_pkg::mau_step_in_t  ua_in, ub_in;
  mau_pkg::mau_step_out_t ua_out, ub_out;

  mau_step u_step_a (.step_i(ua_in), .step_o(ua_out));
  mau_step u_step_b (.step_i(ub_in), .step_o(ub_out));

  logic               last;
  logic [ResBits:0]   sum_ab;
  logic [ResBits-1:0] res_add, res_sub, res_neg, euc_v;
  logic [RawBits-1:0] raw_abs;

  assign last = (cnt_q == '0);

  // unit operand select
  always_comb begin
    ua_in.rem     = acc_q;
    ua_in.bit_in  = 1'b0;
    ua_in.addend  = '0;
    ua_in.divisor = m_q;
    ub_in.rem     = acc2_q;
    ub_in.bit_in  = 1'b0;
    ub_in.addend  = '0;
    ub_in.divisor = m_q;
    unique case (state_q)
      mau_pkg::SRedA, mau_pkg::SRedB, mau_pkg::SRed64: begin
        ua_in.bit_in = sh_q[RawBits-1];
      end
      mau_pkg::SMul: begin
        ua_in.addend = sh_q[RawBits-1] ? a_q : '0;
      end
      mau_pkg::SPowMul: begin
        ua_in.addend = sh_q[RawBits-1] ? r_q : '0;
        ub_in.addend = sh_q[RawBits-1] ? x_q : '0;
      end
      mau_pkg::SEuDiv: begin
        ua_in.bit_in  = sh_q[RawBits-1];
        ua_in.divisor = t_q;
        ub_in.addend  = qbit_q ? m1_q : '0;
      end
      default: begin
      end
    endcase
  end

  // short ops once both operands are reduced
  always_comb begin
    sum_ab  = {1'b0, a_q} + {1'b0, ua_out.nxt};
    res_add = (sum_ab >= {1'b0, m_q}) ? ResBits'(sum_ab - {1'b0, m_q}) : ResBits'(sum_ab);
    res_sub = (a_q >= ua_out.nxt) ? a_q - ua_out.nxt
                                  : ResBits'(({1'b0, a_q} + {1'b0, m_q}) - {1'b0, ua_out.nxt});
    res_neg = (a_q == '0) ? '0 : m_q - a_q;
    euc_v   = (op_q == mau_pkg::OpDiv) ? b_q : a_q;
    raw_abs = in_data_i.raw_value[RawBits-1] ? (~in_data_i.raw_value + RawBits'(1))
                                             : in_data_i.raw_value;
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    m_d     = m_q;
    a_d     = a_q;
    b_d     = b_q;
    e_d     = e_q;
    sh_d    = sh_q;
    acc_d   = acc_q;
    acc2_d  = acc2_q;
    qbit_d  = qbit_q;
    r_d     = r_q;
    x_d     = x_q;
    s_d     = s_q;
    t_d     = t_q;
    m0_d    = m0_q;
    m1_d    = m1_q;
    neg_d   = neg_q;
    res_d   = res_q;
    flag_d  = flag_q;

    unique case (state_q)
      mau_pkg::SIdle: begin
        if (in_valid_i) begin
          op_d   = mau_pkg::mau_op_e'(in_data_i.operation);
          m_d    = modulus_i;
          b_d    = in_data_i.operand_b;
          e_d    = in_data_i.exponent;
          neg_d  = in_data_i.raw_value[RawBits-1];
          acc_d  = '0;
          flag_d = 1'b0;
          if (mau_pkg::mau_op_e'(in_data_i.operation) == mau_pkg::OpRed) begin
            sh_d    = raw_abs;
            cnt_d   = CntBits'(RawBits - 1);
            state_d = mau_pkg::SRed64;
          end else begin
            sh_d    = {in_data_i.operand_a, {PadBits{1'b0}}};
            cnt_d   = CntBits'(ResBits - 1);
            state_d = mau_pkg::SRedA;
          end
        end
      end
      mau_pkg::SRedA: begin
        acc_d = ua_out.nxt;
        sh_d  = sh_q << 1;
        cnt_d = cnt_q - CntBits'(1);
        if (last) begin
          a_d     = ua_out.nxt;
          acc_d   = '0;
          sh_d    = {b_q, {PadBits{1'b0}}};
          cnt_d   = CntBits'(ResBits - 1);
          state_d = mau_pkg::SRedB;
        end
      end
      mau_pkg::SRedB: begin
        acc_d = ua_out.nxt;
        sh_d  = sh_q << 1;
        cnt_d = cnt_q - CntBits'(1);
        if (last) begin
          b_d   = ua_out.nxt;
          acc_d = '0;
          unique case (op_q)
            mau_pkg::OpAdd: begin
              res_d   = res_add;
              state_d = mau_pkg::SOut;
            end
            mau_pkg::OpSub: begin
              res_d   = res_sub;
              state_d = mau_pkg::SOut;
            end
            mau_pkg::OpNeg: begin
              res_d   = res_neg;
              state_d = mau_pkg::SOut;
            end
            mau_pkg::OpMul: begin
              sh_d    = {ua_out.nxt, {PadBits{1'b0}}};
              cnt_d   = CntBits'(ResBits - 1);
              state_d = mau_pkg::SMul;
            end
            mau_pkg::OpPow: begin
              r_d     = (m_q == ResBits'(1)) ? '0 : ResBits'(1);
              x_d     = a_q;
              state_d = mau_pkg::SPow;
            end
            mau_pkg::OpDiv, mau_pkg::OpInv: begin
              state_d = mau_pkg::SEuInit;
            end
            mau_pkg::OpRed: begin
              state_d = mau_pkg::SOut;
            end
            default: begin
              state_d = mau_pkg::SOut;
            end
          endcase
        end
      end
      mau_pkg::SMul: begin
        acc_d = ua_out.nxt;
        sh_d  = sh_q << 1;
        cnt_d = cnt_q - CntBits'(1);
        if (last) begin
          res_d   = ua_out.nxt;
          state_d = mau_pkg::SOut;
        end
      end
      mau_pkg::SPow: begin
        if (e_q == '0) begin
          res_d   = r_q;
          state_d = mau_pkg::SOut;
        end else begin
          sh_d    = {x_q, {PadBits{1'b0}}};
          acc_d   = '0;
          acc2_d  = '0;
          cnt_d   = CntBits'(ResBits - 1);
          state_d = mau_pkg::SPowMul;
        end
      end
      mau_pkg::SPowMul: begin
        // r*x in unit A, x*x in unit B, same multiplier bits
        acc_d  = ua_out.nxt;
        acc2_d = ub_out.nxt;
        sh_d   = sh_q << 1;
        cnt_d  = cnt_q - CntBits'(1);
        if (last) begin
          if (e_q[0]) begin
            r_d = ua_out.nxt;
          end
          x_d     = ub_out.nxt;
          e_d     = e_q >> 1;
          state_d = mau_pkg::SPow;
        end
      end
      mau_pkg::SEuInit: begin
        if (euc_v == '0) begin
          res_d   = '0;
          flag_d  = (m_q != ResBits'(1));
          state_d = mau_pkg::SOut;
        end else begin
          s_d     = m_q;
          t_d     = euc_v;
          m0_d    = '0;
          m1_d    = ResBits'(1);
          state_d = mau_pkg::SEuTest;
        end
      end
      mau_pkg::SEuTest: begin
        if (t_q == '0) begin
          if (s_q == ResBits'(1)) begin
            if (op_q == mau_pkg::OpDiv) begin
              sh_d    = {m0_q, {PadBits{1'b0}}};
              acc_d   = '0;
              cnt_d   = CntBits'(ResBits - 1);
              state_d = mau_pkg::SMul;
            end else begin
              res_d   = m0_q;
              state_d = mau_pkg::SOut;
            end
          end else begin
            res_d   = '0;
            flag_d  = 1'b1;
            state_d = mau_pkg::SOut;
          end
        end else begin
          sh_d    = {s_q, {PadBits{1'b0}}};
          acc_d   = '0;
          acc2_d  = '0;
          qbit_d  = 1'b0;
          cnt_d   = CntBits'(ResBits);
          state_d = mau_pkg::SEuDiv;
        end
      end
      mau_pkg::SEuDiv: begin
        // unit A: s / t, quotient bits MSB first
        // unit B: q * m1 mod m, one bit behind
        acc2_d = ub_out.nxt;
        cnt_d  = cnt_q - CntBits'(1);
        if (last) begin
          qbit_d  = 1'b0;
          state_d = mau_pkg::SEuUpd;
        end else begin
          acc_d  = ua_out.nxt;
          qbit_d = ua_out.took;
          sh_d   = sh_q << 1;
        end
      end
      mau_pkg::SEuUpd: begin
        m1_d    = (m0_q >= acc2_q) ? m0_q - acc2_q
                : ResBits'(({1'b0, m0_q} + {1'b0, m_q}) - {1'b0, acc2_q});
        m0_d    = m1_q;
        s_d     = t_q;
        t_d     = acc_q;
        state_d = mau_pkg::SEuTest;
      end
      mau_pkg::SRed64: begin
        acc_d = ua_out.nxt;
        sh_d  = sh_q << 1;
        cnt_d = cnt_q - CntBits'(1);
        if (last) begin
          if (neg_q && ua_out.nxt != '0) begin
            res_d = m_q - ua_out.nxt;
          end else begin
            res_d = neg_q ? '0 : ua_out.nxt;
          end
          state_d = mau_pkg::SOut;
        end
      end
      mau_pkg::SOut: begin
        if (!out_stall_i) begin
          state_d = mau_pkg::SIdle;
        end
      end
      default: begin
        state_d = mau_pkg::SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mau_pkg::SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    cnt_q  <= cnt_d;
    m_q    <= m_d;
    a_q    <= a_d;
    b_q    <= b_d;
    e_q    <= e_d;
    sh_q   <= sh_d;
    acc_q  <= acc_d;
    acc2_q <= acc2_d;
    qbit_q <= qbit_d;
    r_q    <= r_d;
    x_q    <= x_d;
    s_q    <= s_d;
    t_q    <= t_d;
    m0_q   <= m0_d;
    m1_q   <= m1_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
    flag_q <= flag_d;
  end

  assign in_stall_o            = (state_q != mau_pkg::SIdle);
  assign out_valid_o           = (state_q == mau_pkg::SOut);
  assign out_data_o.result     = res_q;
  assign out_data_o.no_inverse = flag_q;

endmodule

/* src/modular_arithmetic_unit.sv */
// Top level of the modular arithmetic unit.
// Depends on mau_pkg, mau_regs, mau_seq (and mau_step), defines header.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------
//  in       | input     | in_valid_i / in_stall_o | in_data_i  (mau_in_t)
//  out      | output    | out_valid_o / out_stall_i | out_data_o (mau_out_t)
//  cfg      | input     | psel/penable/pwrite     | paddr, pwdata, prdata
//
// One transaction at a time. Operands are first reduced mod m, one bit per cycle;
// add/sub/neg then finish at once, mul runs a further shift-and-add pass.
// Pow runs one multiply pass per exponent bit up to the highest set bit (r*x
// and x*x share the bits of x in the two step units); inverse/div run a test,
// a division and an update per Euclid step. Result is held in an
// output register until taken; in_stall_o is high from acceptance until then.
// Reset returns the sequencer to idle and the modulus to 998244353.

`include "modular_arithmetic_unit_defines.svh"

module modular_arithmetic_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  mau_pkg::mau_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output mau_pkg::mau_out_t            out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mau_pkg::AddrBits-1:0] paddr,
  input  logic [mau_pkg::DataBits-1:0] pwdata,
  output logic [mau_pkg::DataBits-1:0] prdata,
  output logic                         pready
);

  logic [mau_pkg::ResBits-1:0] modulus;

  // modulus register
  mau_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .modulus_o (modulus)
  );

  // sequencer + shared step units
  mau_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .modulus_i   (modulus),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // a pending result keeps the input closed
  `MAU_ASSERT_NEVER(a_out_while_open, clk_i, rst_ni, out_valid_o && !in_stall_o)
  // accepting a transaction closes the input next cycle
  `MAU_ASSERT(a_accept_busy, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  // no inverse always reports a zero residue
  `MAU_ASSERT(a_flag_zero, clk_i, rst_ni, (out_valid_o && out_data_o.no_inverse) |-> (out_data_o.result == '0))

endmodule
